[design/mbs_pkg.sv]
// Package for the masked beam spectrum block.
// Holds the item types, the queue command type and shared arithmetic helpers.
// Has no dependencies.
package mbs_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam logic [16:0] PROB_ONE = 17'd65536;

    typedef struct packed {
        logic               func;
        logic [4:0]         angle_index;
        logic [7:0]         bin_index;
        logic [2:0]         row_index;
        logic [2:0]         col_index;
        logic signed [23:0] sig_re;
        logic signed [23:0] sig_im;
        logic signed [23:0] noise_re;
        logic signed [23:0] noise_im;
        logic [16:0]        mask_prob;
        logic               last_element;
    } mbs_in_t;

    typedef struct packed {
        logic [4:0]  out_angle;
        logic [16:0] spec_value;
        logic        div_error;
        logic        last_angle;
    } mbs_out_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_WEIGHT,
        OP_ACCUM
    } mbs_op_t;

    typedef struct packed {
        mbs_op_t            op;
        logic               emit;
        logic [4:0]         angle;
        logic [7:0]         bin;
        logic [2:0]         row;
        logic [2:0]         col;
        logic [31:0]        weight;
        logic signed [23:0] sr;
        logic signed [23:0] si;
        logic signed [23:0] nr;
        logic signed [23:0] ni;
        logic [16:0]        prob;
    } mbs_cmd_t;

    function automatic logic [15:0] sat16(input logic signed [23:0] v);
        logic [15:0] r;
        if (v > 24'sd32767)
        begin
            r = 16'h7fff;
        end
        else if (v < -24'sd32768)
        begin
            r = 16'h8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        logic signed [63:0] r;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
        begin
            r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        else
        begin
            r = s[63:0];
        end
        return r;
    endfunction

endpackage

[design/mbs_front.sv]
// Front part: accepts input items and classifies them into queue commands.
// Depends on mbs_pkg.
module mbs_front #(
    parameter int ANGLES   = 32,
    parameter int BINS     = 256,
    parameter int CHANNELS = 8
) (
    input  logic              in_valid,
    output logic              in_ready,
    input  mbs_pkg::mbs_in_t  in_data,
    input  logic [3:0]        channel_count,
    input  logic              q_full,
    output logic              q_push,
    output mbs_pkg::mbs_cmd_t q_cmd
);
    import mbs_pkg::*;

    logic [4:0] nc;
    logic       wt_ok;
    logic       acc_ok;

    always_comb
    begin
        if (channel_count == 4'd0)
        begin
            nc = 5'd1;
        end
        else if (32'(channel_count) > CHANNELS)
        begin
            nc = 5'(CHANNELS);
        end
        else
        begin
            nc = {1'b0, channel_count};
        end
    end

    assign wt_ok  = (32'(in_data.angle_index) < ANGLES) && (32'(in_data.bin_index) < BINS)
                    && (32'(in_data.row_index) < CHANNELS);
    assign acc_ok = ({2'b00, in_data.row_index} < nc) && ({2'b00, in_data.col_index} < nc)
                    && (32'(in_data.bin_index) < BINS);

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_cmd.emit   = in_data.func && in_data.last_element;
        q_cmd.angle  = in_data.angle_index;
        q_cmd.bin    = in_data.bin_index;
        q_cmd.row    = in_data.row_index;
        q_cmd.col    = in_data.col_index;
        q_cmd.weight = {sat16(in_data.sig_im), sat16(in_data.sig_re)};
        q_cmd.sr     = in_data.sig_re;
        q_cmd.si     = in_data.sig_im;
        q_cmd.nr     = in_data.noise_re;
        q_cmd.ni     = in_data.noise_im;
        q_cmd.prob   = (in_data.mask_prob > PROB_ONE) ? PROB_ONE : in_data.mask_prob;
        if (!in_data.func)
        begin
            q_cmd.op = wt_ok ? OP_WEIGHT : OP_NONE;
        end
        else
        begin
            q_cmd.op = acc_ok ? OP_ACCUM : OP_NONE;
        end
    end

endmodule

[design/mbs_queue.sv]
// Short command queue between the front and back parts.
// Depends on mbs_pkg.
module mbs_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mbs_pkg::mbs_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              q_valid,
    output mbs_pkg::mbs_cmd_t q_cmd
);
    import mbs_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    mbs_cmd_t        mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW:0]     count_reg;
    logic [PW:0]     count_next;

    assign full    = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !(pop && q_valid))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop && q_valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && q_valid)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[design/mbs_back.sv]
// Back part: weight memory, per-angle quadratic form pipeline, accumulators
// and the emission sequencer with its bit-serial divider. Depends on mbs_pkg.
module mbs_back #(
    parameter int ANGLES   = 32,
    parameter int BINS     = 256,
    parameter int CHANNELS = 8,
    localparam int NW      = $clog2(ANGLES + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [NW-1:0]     na,
    input  logic              q_valid,
    input  mbs_pkg::mbs_cmd_t q_cmd,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output mbs_pkg::mbs_out_t out_data
);
    import mbs_pkg::*;

    localparam int AW     = (ANGLES > 1) ? $clog2(ANGLES) : 1;
    localparam int WDEPTH = ANGLES * BINS * CHANNELS;
    localparam int WAW    = $clog2(WDEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PIPE,
        ST_DRAIN,
        ST_EM_RD,
        ST_EM_LD,
        ST_DIV,
        ST_MUL,
        ST_OUT
    } state_t;

    state_t    st_reg;
    mbs_cmd_t  cur_reg;
    logic [AW-1:0] n_reg;
    logic [AW-1:0] e_reg;
    logic [3:0]    cnt_reg;
    logic [63:0]   rem_reg;
    logic [63:0]   d_reg;
    logic [16:0]   ratio_reg;
    mbs_out_t      out_reg;

    logic [31:0] wmem [WDEPTH];
    logic [31:0] rd_a_reg;
    logic [31:0] rd_b_reg;
    logic [WAW-1:0] wr_addr;
    logic [WAW-1:0] addr_a;
    logic [WAW-1:0] addr_b;
    logic           wr_en;

    logic signed [63:0] acc_s [ANGLES];
    logic signed [63:0] acc_n [ANGLES];
    logic signed [63:0] acc_s_rd_reg;
    logic signed [63:0] acc_n_rd_reg;
    logic [ANGLES-1:0]  acc_vld_reg;
    logic [AW-1:0]      acc_raddr;
    logic               clear_all;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic [AW-1:0] t1_reg, t2_reg, t3_reg, t4_reg;
    logic signed [15:0] a2r_reg, a2i_reg, a3r_reg, a3i_reg;
    logic signed [39:0] ps_rr_reg, ps_ii_reg, ps_ri_reg, ps_ir_reg;
    logic signed [39:0] pn_rr_reg, pn_ii_reg, pn_ri_reg, pn_ir_reg;
    logic signed [40:0] zs_re_reg, zs_im_reg, zn_re_reg, zn_im_reg;
    logic signed [56:0] qs_r_reg, qs_i_reg, qn_r_reg, qn_i_reg;

    logic signed [15:0] br, bi;
    logic signed [57:0] term_s, term_n;
    logic signed [63:0] base_s, base_n;
    logic signed [63:0] f1, fn, dsum;
    logic [63:0]        num;
    logic [63:0]        rem2;
    logic [33:0]        prod;
    logic               issue_last;
    logic               emit_last;

    assign q_pop      = (st_reg == ST_IDLE) && q_valid;
    assign wr_en      = q_pop && (q_cmd.op == OP_WEIGHT);
    assign wr_addr    = WAW'((32'(q_cmd.angle) * BINS + 32'(q_cmd.bin)) * CHANNELS
                             + 32'(q_cmd.row));
    assign addr_a     = WAW'((32'(n_reg) * BINS + 32'(cur_reg.bin)) * CHANNELS
                             + 32'(cur_reg.row));
    assign addr_b     = WAW'((32'(n_reg) * BINS + 32'(cur_reg.bin)) * CHANNELS
                             + 32'(cur_reg.col));
    assign issue_last = (NW'(n_reg) + 1'b1 == na);
    assign emit_last  = (NW'(e_reg) + 1'b1 == na);
    assign acc_raddr  = (st_reg == ST_EM_RD) ? e_reg : t3_reg;
    assign clear_all  = (st_reg == ST_OUT) && out_ready && emit_last;
    assign out_valid  = (st_reg == ST_OUT);
    assign out_data   = out_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wmem[wr_addr] <= q_cmd.weight;
        end
        rd_a_reg <= wmem[addr_a];
        rd_b_reg <= wmem[addr_b];
    end

    assign br = signed'(rd_b_reg[15:0]);
    assign bi = signed'(rd_b_reg[31:16]);

    always_ff @(posedge clk)
    begin
        ps_rr_reg <= cur_reg.sr * br;
        ps_ii_reg <= cur_reg.si * bi;
        ps_ri_reg <= cur_reg.sr * bi;
        ps_ir_reg <= cur_reg.si * br;
        pn_rr_reg <= cur_reg.nr * br;
        pn_ii_reg <= cur_reg.ni * bi;
        pn_ri_reg <= cur_reg.nr * bi;
        pn_ir_reg <= cur_reg.ni * br;
        a2r_reg   <= signed'(rd_a_reg[15:0]);
        a2i_reg   <= signed'(rd_a_reg[31:16]);
        zs_re_reg <= ps_rr_reg - ps_ii_reg;
        zs_im_reg <= ps_ri_reg + ps_ir_reg;
        zn_re_reg <= pn_rr_reg - pn_ii_reg;
        zn_im_reg <= pn_ri_reg + pn_ir_reg;
        a3r_reg   <= a2r_reg;
        a3i_reg   <= a2i_reg;
        qs_r_reg  <= a3r_reg * zs_re_reg;
        qs_i_reg  <= a3i_reg * zs_im_reg;
        qn_r_reg  <= a3r_reg * zn_re_reg;
        qn_i_reg  <= a3i_reg * zn_im_reg;
        t1_reg    <= n_reg;
        t2_reg    <= t1_reg;
        t3_reg    <= t2_reg;
        t4_reg    <= t3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= (st_reg == ST_PIPE);
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_comb
    begin
        term_s = 58'(qs_r_reg) + 58'(qs_i_reg);
        term_n = 58'(qn_r_reg) + 58'(qn_i_reg);
        base_s = acc_vld_reg[t4_reg] ? acc_s_rd_reg : 64'sd0;
        base_n = acc_vld_reg[t4_reg] ? acc_n_rd_reg : 64'sd0;
        f1     = acc_vld_reg[e_reg] ? acc_s_rd_reg : 64'sd0;
        fn     = acc_vld_reg[e_reg] ? acc_n_rd_reg : 64'sd0;
        dsum   = sat_add64(f1, fn);
        num    = f1[63] ? 64'd0 : f1;
        rem2   = {rem_reg[62:0], 1'b0};
        prod   = cur_reg.prob * ratio_reg;
    end

    always_ff @(posedge clk)
    begin
        if (v4_reg)
        begin
            acc_s[t4_reg] <= sat_add64(base_s, 64'(term_s));
            acc_n[t4_reg] <= sat_add64(base_n, 64'(term_n));
        end
        acc_s_rd_reg <= acc_s[acc_raddr];
        acc_n_rd_reg <= acc_n[acc_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_vld_reg <= '0;
        end
        else if (clear_all)
        begin
            acc_vld_reg <= '0;
        end
        else if (v4_reg)
        begin
            acc_vld_reg[t4_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_IDLE;
            n_reg     <= '0;
            e_reg     <= '0;
            cnt_reg   <= '0;
            cur_reg   <= '0;
            rem_reg   <= '0;
            d_reg     <= '0;
            ratio_reg <= '0;
            out_reg   <= '0;
        end
        else
        begin
            case (st_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        cur_reg <= q_cmd;
                        n_reg   <= '0;
                        e_reg   <= '0;
                        if (q_cmd.op == OP_ACCUM)
                        begin
                            st_reg <= ST_PIPE;
                        end
                        else if (q_cmd.emit)
                        begin
                            st_reg <= ST_EM_RD;
                        end
                    end
                end
                ST_PIPE:
                begin
                    n_reg <= n_reg + 1'b1;
                    if (issue_last)
                    begin
                        st_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (!v1_reg && !v2_reg && !v3_reg && !v4_reg)
                    begin
                        st_reg <= cur_reg.emit ? ST_EM_RD : ST_IDLE;
                    end
                end
                ST_EM_RD:
                begin
                    st_reg <= ST_EM_LD;
                end
                ST_EM_LD:
                begin
                    d_reg              <= dsum;
                    rem_reg            <= num;
                    ratio_reg          <= '0;
                    cnt_reg            <= '0;
                    out_reg.out_angle  <= 5'(e_reg);
                    out_reg.last_angle <= emit_last;
                    if (dsum[63] || (dsum == 64'sd0))
                    begin
                        out_reg.spec_value <= '0;
                        out_reg.div_error  <= 1'b1;
                        st_reg             <= ST_OUT;
                    end
                    else if (num >= dsum)
                    begin
                        ratio_reg <= PROB_ONE;
                        st_reg    <= ST_MUL;
                    end
                    else
                    begin
                        st_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (rem2 >= d_reg)
                    begin
                        rem_reg   <= rem2 - d_reg;
                        ratio_reg <= {ratio_reg[15:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg   <= rem2;
                        ratio_reg <= {ratio_reg[15:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 4'd15)
                    begin
                        st_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    out_reg.spec_value <= prod[32:16];
                    out_reg.div_error  <= 1'b0;
                    st_reg             <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        if (emit_last)
                        begin
                            st_reg <= ST_IDLE;
                        end
                        else
                        begin
                            e_reg  <= e_reg + 1'b1;
                            st_reg <= ST_EM_RD;
                        end
                    end
                end
                default:
                begin
                    st_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[design/masked_beam_spectrum_core.sv]
// Top level of the masked beam spectrum block: configuration registers,
// front classifier, command queue and back part. Depends on mbs_pkg,
// mbs_front, mbs_queue and mbs_back.
//
// A weight load is written to the weight memory from the idle state of the back
// part. For a covariance element inside the matrix, the back part reads both
// weights of one angle per cycle from the weight memory's two read ports and
// drains its multiply pipeline before the next element. On the last element
// each angle's result is worked out by the emission sequencer and its
// one-bit-per-cycle divider, and waits until it is taken.
// The front keeps accepting items into a four-entry queue meanwhile.
// Accumulators are cleared through per-angle valid bits, so there is no
// clearing pass after reset; the weight memory holds garbage until written.
module masked_beam_spectrum_core #(
    parameter int ANGLES   = 32,
    parameter int BINS     = 256,
    parameter int CHANNELS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mbs_pkg::mbs_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output mbs_pkg::mbs_out_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [3:0]        cfg_index,
    input  logic [7:0]        cfg_data
);
    import mbs_pkg::*;

    localparam int NW = $clog2(ANGLES + 1);
    localparam logic [3:0] REG_CHANNEL_COUNT = 4'd0;
    localparam logic [3:0] REG_ANGLE_COUNT   = 4'd1;

    logic [3:0]    channel_count_reg;
    logic [5:0]    angle_count_reg;
    logic [NW-1:0] na;
    logic          q_full;
    logic          q_push;
    logic          q_pop;
    logic          q_valid;
    mbs_cmd_t      push_cmd;
    mbs_cmd_t      q_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_count_reg <= 4'd4;
            angle_count_reg   <= 6'd32;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[3:0];
                REG_ANGLE_COUNT:   angle_count_reg   <= cfg_data[5:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        if (angle_count_reg == 6'd0)
        begin
            na = NW'(1);
        end
        else if (32'(angle_count_reg) > ANGLES)
        begin
            na = NW'(ANGLES);
        end
        else
        begin
            na = NW'(angle_count_reg);
        end
    end

    mbs_front #(
        .ANGLES   (ANGLES),
        .BINS     (BINS),
        .CHANNELS (CHANNELS)
    ) u_front (
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .channel_count (channel_count_reg),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (push_cmd)
    );

    mbs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    mbs_back #(
        .ANGLES   (ANGLES),
        .BINS     (BINS),
        .CHANNELS (CHANNELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .na        (na),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[design/mbs_checker.sv]
// Port-level checker for masked_beam_spectrum_core and its bind statement.
// Depends on mbs_pkg.
module mbs_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input mbs_pkg::mbs_out_t out_data
);
    import mbs_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("Result item changed while stalled.");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.div_error |-> out_data.spec_value == 17'd0)
        else $error("Division error item carries a nonzero value.");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.spec_value <= PROB_ONE)
        else $error("Spectrum value above one.");

endmodule

bind masked_beam_spectrum_core mbs_checker u_mbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

[test/tb.sv]
// Testbench for masked_beam_spectrum_core: weight loads, covariance streams,
// register writes, with a scoreboard that predicts every spectrum item.
// Depends on mbs_pkg and the design files of the block.
`timescale 1ns / 1ps

module tb;
    import mbs_pkg::*;

    localparam int ANGLES = 32;
    localparam int BINS = 256;
    localparam int CHANNELS = 8;
    localparam logic [3:0] REG_CHANNELS = 4'd0;
    localparam logic [3:0] REG_ANGLES = 4'd1;
    localparam logic [3:0] REG_UNUSED = 4'd15;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE_CYCLES = 400;

    class spectrum_scoreboard;
        logic [31:0] weights [ANGLES*BINS*CHANNELS];
        bit          weight_set [ANGLES*BINS*CHANNELS];
        longint      sig_power [ANGLES];
        longint      noise_power [ANGLES];
        logic [3:0]  chan_reg;
        logic [5:0]  angle_reg;
        mbs_out_t    spectrum_due [$];
        int          mismatches;

        function new();
            chan_reg = 4'd4;
            angle_reg = 6'd32;
            mismatches = 0;
            for (int n = 0; n < ANGLES; n++)
            begin
                sig_power[n] = 0;
                noise_power[n] = 0;
            end
        endfunction

        function int angles_used();
            int a;
            a = angle_reg;
            if (a < 1) a = 1;
            if (a > ANGLES) a = ANGLES;
            return a;
        endfunction

        function int channels_used();
            int c;
            c = chan_reg;
            if (c < 1) c = 1;
            if (c > CHANNELS) c = CHANNELS;
            return c;
        endfunction

        function int slot(int ang, int bin, int ch);
            return (ang * BINS + bin) * CHANNELS + ch;
        endfunction

        function bit bin_loaded(int bin, int row, int col);
            for (int n = 0; n < angles_used(); n++)
            begin
                if (!weight_set[slot(n, bin, row)] || !weight_set[slot(n, bin, col)])
                begin
                    return 0;
                end
            end
            return 1;
        endfunction

        function void write_reg(logic [3:0] idx, logic [7:0] data);
            if (idx == REG_CHANNELS) chan_reg = data[3:0];
            else if (idx == REG_ANGLES) angle_reg = data[5:0];
        endfunction

        function logic [15:0] clip16(longint v);
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return v[15:0];
        endfunction

        function longint add_clip(longint a, longint b);
            longint s;
            s = a + b;
            if (a[63] == b[63] && s[63] != a[63])
            begin
                s = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            end
            return s;
        endfunction

        function longint quad(longint mr, longint mi, longint ar, longint ai,
                              longint br, longint bi);
            longint zr;
            longint zi;
            zr = mr * br - mi * bi;
            zi = mr * bi + mi * br;
            return ar * zr + ai * zi;
        endfunction

        function void note_input(mbs_in_t x);
            int na;
            int nc;
            logic [31:0] wa;
            logic [31:0] wb;
            longint ar, ai, br, bi, f1, d;
            logic [79:0] ratio;
            logic [63:0] num;
            logic [63:0] spec;
            logic [16:0] prob;
            mbs_out_t r;
            na = angles_used();
            nc = channels_used();
            if (x.func == 1'b0)
            begin
                weights[slot(x.angle_index, x.bin_index, x.row_index)] =
                    {clip16(longint'(x.sig_im)), clip16(longint'(x.sig_re))};
                weight_set[slot(x.angle_index, x.bin_index, x.row_index)] = 1;
                return;
            end
            if (x.row_index < nc && x.col_index < nc)
            begin
                for (int n = 0; n < na; n++)
                begin
                    wa = weights[slot(n, x.bin_index, x.row_index)];
                    wb = weights[slot(n, x.bin_index, x.col_index)];
                    ar = longint'($signed(wa[15:0]));
                    ai = longint'($signed(wa[31:16]));
                    br = longint'($signed(wb[15:0]));
                    bi = longint'($signed(wb[31:16]));
                    sig_power[n] = add_clip(sig_power[n], quad(longint'(x.sig_re),
                        longint'(x.sig_im), ar, ai, br, bi));
                    noise_power[n] = add_clip(noise_power[n], quad(longint'(x.noise_re),
                        longint'(x.noise_im), ar, ai, br, bi));
                end
            end
            if (!x.last_element) return;
            prob = (x.mask_prob > PROB_ONE) ? PROB_ONE : x.mask_prob;
            for (int n = 0; n < na; n++)
            begin
                f1 = sig_power[n];
                d = add_clip(f1, noise_power[n]);
                r.out_angle = n[4:0];
                r.last_angle = (n == na - 1);
                if (d <= 0)
                begin
                    r.div_error = 1'b1;
                    r.spec_value = '0;
                end
                else
                begin
                    num = (f1 < 0) ? 64'd0 : f1;
                    if (num >= d) ratio = 80'd65536;
                    else ratio = {num, 16'd0} / {16'd0, d};
                    spec = (64'(prob) * ratio[63:0]) >> 16;
                    r.div_error = 1'b0;
                    r.spec_value = spec[16:0];
                end
                spectrum_due.push_back(r);
            end
            for (int n = 0; n < ANGLES; n++)
            begin
                sig_power[n] = 0;
                noise_power[n] = 0;
            end
        endfunction

        function void check_result(mbs_out_t got);
            mbs_out_t want;
            if (spectrum_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected spectrum item: angle %0d value %0d err %0b last %0b",
                             got.out_angle, got.spec_value, got.div_error, got.last_angle);
                return;
            end
            want = spectrum_due.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"Mismatch: expected angle %0d value %0d err %0b last %0b,",
                              " got angle %0d value %0d err %0b last %0b"},
                             want.out_angle, want.spec_value, want.div_error,
                             want.last_angle, got.out_angle, got.spec_value,
                             got.div_error, got.last_angle);
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    mbs_in_t    in_data;
    logic       out_valid;
    logic       out_ready;
    mbs_out_t   out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [3:0] cfg_index;
    logic [7:0] cfg_data;

    spectrum_scoreboard sb;
    int  burst_left;
    bit  hold_request;
    int  cycle_count;
    int  random_count;

    masked_beam_spectrum_core #(
        .ANGLES(ANGLES),
        .BINS(BINS),
        .CHANNELS(CHANNELS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // The receiver switches between stall patterns and serves long hold-offs.
    initial
    begin
        int mode;
        int left;
        mode = 0;
        left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 0;
                out_ready <= 1'b0;
                repeat (SETTLE_CYCLES) @(negedge clk);
            end
            if (left == 0)
            begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(10, 80);
            end
            left--;
            case (mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                default: out_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result(out_data);
        end
    end

    task automatic send(input mbs_in_t x);
        @(negedge clk);
        in_valid <= 1'b1;
        in_data <= x;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_input(x);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(1, 12);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
        end
        else
        begin
            burst_left--;
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.spectrum_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [7:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [23:0] rand24();
        case ($urandom_range(0, 5))
            0: return 24'h7fffff;
            1: return 24'h800000;
            2: return 24'($signed($urandom_range(0, 4095)) - 2048);
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic logic [16:0] rand_prob();
        case ($urandom_range(0, 4))
            0: return PROB_ONE;
            1: return 17'($urandom_range(65537, 131071));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    function automatic mbs_in_t weight_item(int ang, int bin, int ch);
        mbs_in_t x;
        x.noise_re = 24'($urandom());
        x.noise_im = 24'($urandom());
        x.mask_prob = 17'($urandom());
        x.col_index = 3'($urandom());
        x.last_element = 1'($urandom());
        x.func = 1'b0;
        x.angle_index = 5'(ang);
        x.bin_index = 8'(bin);
        x.row_index = 3'(ch);
        x.sig_re = ($urandom_range(0, 7) == 0) ? rand24() : 24'($signed(16'($urandom())));
        x.sig_im = ($urandom_range(0, 7) == 0) ? rand24() : 24'($signed(16'($urandom())));
        return x;
    endfunction

    function automatic mbs_in_t cov_item(int bin, int row, int col, bit last);
        mbs_in_t x;
        x.func = 1'b1;
        x.angle_index = 5'($urandom());
        x.bin_index = 8'(bin);
        x.row_index = 3'(row);
        x.col_index = 3'(col);
        x.sig_re = rand24();
        x.sig_im = rand24();
        x.noise_re = rand24();
        x.noise_im = rand24();
        x.mask_prob = rand_prob();
        x.last_element = last;
        if (row < sb.channels_used() && col < sb.channels_used()
            && !sb.bin_loaded(bin, row, col))
        begin
            x.bin_index = 8'd255;
        end
        return x;
    endfunction

    // Loads every weight of the bin that the current register values reach and that is not yet set.
    task automatic load_weights(input int bin);
        for (int n = 0; n < sb.angles_used(); n++)
        begin
            for (int ch = 0; ch < sb.channels_used(); ch++)
            begin
                if (!sb.weight_set[sb.slot(n, bin, ch)])
                begin
                    send(weight_item(n, bin, ch));
                end
            end
        end
    endtask

    task automatic send_matrix(input bit cut_short);
        int c;
        int bin;
        int stop;
        c = sb.channels_used();
        bin = ($urandom_range(0, 1) == 0) ? 0 : 255;
        stop = cut_short ? $urandom_range(0, c * c - 1) : c * c - 1;
        for (int k = 0; k <= stop; k++)
        begin
            send(cov_item(bin, k / c, k % c, k == stop));
            random_count++;
        end
    endtask

    task automatic random_phase(input int amount);
        int start;
        int r;
        int row;
        start = random_count;
        while (random_count - start < amount)
        begin
            r = $urandom_range(0, 9);
            if (r <= 5)
            begin
                send_matrix(0);
            end
            else if (r == 6)
            begin
                send_matrix(1);
            end
            else if (r == 7)
            begin
                send(weight_item($urandom_range(0, ANGLES - 1),
                    ($urandom_range(0, 1) == 0) ? $urandom_range(0, 255) : 255,
                    $urandom_range(0, CHANNELS - 1)));
                random_count++;
            end
            else
            begin
                row = $urandom_range(0, CHANNELS - 1);
                send(cov_item($urandom_range(0, 255), row,
                    $urandom_range(0, CHANNELS - 1), $urandom_range(0, 3) == 0));
                random_count++;
            end
        end
        send(cov_item(0, 0, 0, 1));
    endtask

    initial
    begin
        mbs_in_t x;
        int settings [9][2];
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        burst_left = 0;
        hold_request = 0;
        random_count = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed items: saturating weight loads, elements outside the matrix
        // at the reset register values, extreme covariance values and
        // probability limits.
        x = weight_item(3, 0, 1);
        x.sig_re = 24'h7fffff;
        x.sig_im = 24'h800000;
        x.last_element = 1'b1;
        send(x);
        x = weight_item(31, 255, 7);
        x.sig_re = 24'h800000;
        x.sig_im = 24'h7fffff;
        send(x);
        x = cov_item(0, 5, 1, 1);
        x.mask_prob = 17'd0;
        send(x);
        x = cov_item(0, 1, 6, 1);
        x.mask_prob = PROB_ONE;
        send(x);
        hold_request = 1;
        for (int k = 0; k < 6; k++)
        begin
            send(cov_item(0, 4 + k % 4, k, 1'b1));
        end
        wait_idle();

        write_reg(REG_ANGLES, 8'd4);
        load_weights(255);
        send(cov_item(0, 0, 0, 1));
        for (int k = 0; k < 16; k++)
        begin
            x = cov_item(255, k / 4, k % 4, k == 15);
            x.sig_re = (k % 2) ? 24'h7fffff : 24'h800000;
            x.sig_im = 24'h7fffff;
            x.noise_re = 24'h800000;
            x.noise_im = 24'h800000;
            x.mask_prob = (k == 15) ? 17'h1ffff : 17'd0;
            send(x);
        end
        wait_idle();

        settings = '{'{1, 1}, '{8, 4}, '{0, 0}, '{15, 2}, '{5, 1},
                     '{0, 63}, '{3, 7}, '{8'hf6, 8'h45}, '{2, 8'hc5}};
        write_reg(REG_UNUSED, 8'hff);
        for (int p = 0; p < 9; p++)
        begin
            write_reg(REG_CHANNELS, 8'(settings[p][0]));
            write_reg(REG_ANGLES, 8'(settings[p][1]));
            load_weights(255);
            if (p == 1) hold_request = 1;
            random_phase(6);
            wait_idle();
        end

        if (sb.mismatches == 0 && sb.spectrum_due.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
